// ----- design/adsr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the linear ADSR envelope level block.
package adsr_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned STAGE_W   = 3;
  localparam int unsigned FRAC_W    = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MIN_STAGE = 7;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

  localparam int unsigned RST_ATTACK  = 655;
  localparam int unsigned RST_DECAY   = 6554;
  localparam int unsigned RST_SUSTAIN = 22938;
  localparam int unsigned RST_HOLD    = 32768;
  localparam int unsigned RST_RELEASE = 13107;

  typedef enum logic [STAGE_W-1:0] {
    ST_ATTACK  = 3'd0,
    ST_DECAY   = 3'd1,
    ST_HOLD    = 3'd2,
    ST_RELEASE = 3'd3,
    ST_DONE    = 3'd4
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_HOLD    = 3'd3,
    REG_RELEASE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    stage_t              stage;
    logic [LEVEL_W-1:0]  base;
  } ctrl_t;

endpackage

// ----- design/adsr_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers with minimum stage length and sustain saturation.
module adsr_cfg #(
  parameter int TIME_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIME_BITS-1:0]             cfg_wdata,
  output logic [TIME_BITS-1:0]             attack_eff,
  output logic [TIME_BITS-1:0]             decay_eff,
  output logic [TIME_BITS-1:0]             hold_eff,
  output logic [TIME_BITS-1:0]             release_eff,
  output logic [adsr_pkg::LEVEL_W-1:0]     sustain_eff
);
  import adsr_pkg::*;

  localparam logic [TIME_BITS-1:0] MIN_T = TIME_BITS'(MIN_STAGE);

  logic [TIME_BITS-1:0] attack_time;
  logic [TIME_BITS-1:0] decay_time;
  logic [LEVEL_W-1:0]   sustain_level;
  logic [TIME_BITS-1:0] hold_time;
  logic [TIME_BITS-1:0] release_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time   <= TIME_BITS'(RST_ATTACK);
      decay_time    <= TIME_BITS'(RST_DECAY);
      sustain_level <= LEVEL_W'(RST_SUSTAIN);
      hold_time     <= TIME_BITS'(RST_HOLD);
      release_time  <= TIME_BITS'(RST_RELEASE);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTACK:  attack_time   <= cfg_wdata;
        REG_DECAY:   decay_time    <= cfg_wdata;
        REG_SUSTAIN: sustain_level <= cfg_wdata[LEVEL_W-1:0];
        REG_HOLD:    hold_time     <= cfg_wdata;
        REG_RELEASE: release_time  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign attack_eff  = (attack_time < MIN_T) ? MIN_T : attack_time;
  assign decay_eff   = (decay_time < MIN_T) ? MIN_T : decay_time;
  assign release_eff = (release_time < MIN_T) ? MIN_T : release_time;
  assign hold_eff    = hold_time;
  assign sustain_eff = (sustain_level > FULL_SCALE) ? FULL_SCALE : sustain_level;

endmodule

// ----- design/adsr_sel.sv -----
`timescale 1ns / 1ps
// Four-stage stage classifier: picks offset, divisor, multiplier and base level.
module adsr_sel #(
  parameter int TIME_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TIME_BITS-1:0]           in_time,
  input  logic [TIME_BITS-1:0]           attack_eff,
  input  logic [TIME_BITS-1:0]           decay_eff,
  input  logic [TIME_BITS-1:0]           hold_eff,
  input  logic [TIME_BITS-1:0]           release_eff,
  input  logic [adsr_pkg::LEVEL_W-1:0]   sustain_eff,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [TIME_BITS-1:0]           out_x,
  output logic [TIME_BITS-1:0]           out_div,
  output logic [adsr_pkg::LEVEL_W-1:0]   out_mult,
  output adsr_pkg::ctrl_t                out_ctrl
);
  import adsr_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic p1, p2, p3;
  logic [TIME_BITS-1:0] x1, x2, x3, x4;
  logic [TIME_BITS-1:0] dv1, dv2, dv3, dv4;
  stage_t st2, st3;
  logic [LEVEL_W-1:0] m4;
  ctrl_t ctrl4;

  logic lt_a, lt_d, lt_h, lt_r;
  stage_t fs;
  logic [LEVEL_W-1:0] mult_sel;
  logic [LEVEL_W-1:0] base_sel;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign lt_a = in_time < attack_eff;
  assign lt_d = x1 < decay_eff;
  assign lt_h = x2 < hold_eff;
  assign lt_r = x3 < release_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1  <= lt_a ? in_time : in_time - attack_eff;
      p1  <= !lt_a;
      dv1 <= attack_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x2  <= (p1 && !lt_d) ? x1 - decay_eff : x1;
      p2  <= p1 && !lt_d;
      st2 <= p1 ? ST_DECAY : ST_ATTACK;
      dv2 <= (p1 && lt_d) ? decay_eff : dv1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      x3  <= (p2 && !lt_h) ? x2 - hold_eff : x2;
      p3  <= p2 && !lt_h;
      st3 <= p2 ? ST_HOLD : st2;
      dv3 <= dv2;
    end
  end

  always_comb begin
    fs = p3 ? (lt_r ? ST_RELEASE : ST_DONE) : st3;
    case (fs)
      ST_ATTACK: begin
        mult_sel = FULL_SCALE;
        base_sel = '0;
      end
      ST_DECAY: begin
        mult_sel = FULL_SCALE - sustain_eff;
        base_sel = FULL_SCALE;
      end
      ST_HOLD: begin
        mult_sel = '0;
        base_sel = sustain_eff;
      end
      ST_RELEASE: begin
        mult_sel = sustain_eff;
        base_sel = sustain_eff;
      end
      default: begin
        mult_sel = '0;
        base_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      x4          <= x3;
      dv4         <= (p3 && lt_r) ? release_eff : dv3;
      m4          <= mult_sel;
      ctrl4.stage <= fs;
      ctrl4.base  <= base_sel;
    end
  end

  assign out_valid = v4;
  assign out_x     = x4;
  assign out_div   = dv4;
  assign out_mult  = m4;
  assign out_ctrl  = ctrl4;

endmodule

// ----- design/adsr_div.sv -----
`timescale 1ns / 1ps
// Multiply stage followed by a restoring divider, one quotient bit per stage.
module adsr_div #(
  parameter int TIME_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TIME_BITS-1:0]           in_x,
  input  logic [TIME_BITS-1:0]           in_div,
  input  logic [adsr_pkg::LEVEL_W-1:0]   in_mult,
  input  adsr_pkg::ctrl_t                in_ctrl,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [adsr_pkg::FRAC_W-1:0]    out_quot,
  output adsr_pkg::ctrl_t                out_ctrl
);
  import adsr_pkg::*;

  localparam int PROD_W = TIME_BITS + LEVEL_W;

  logic [PROD_W-1:0]    prod;
  logic [TIME_BITS-1:0] rem [0:FRAC_W];
  logic [FRAC_W-1:0]    qb  [0:FRAC_W];
  logic [TIME_BITS-1:0] dv  [0:FRAC_W];
  ctrl_t                ctl [0:FRAC_W];
  logic                 vld [0:FRAC_W];
  logic                 rdy [0:FRAC_W];

  assign prod = in_x * in_mult;

  assign rdy[FRAC_W] = !vld[FRAC_W] || out_ready;
  assign rdy[0]      = !vld[0] || rdy[1];
  assign in_ready    = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= prod[TIME_BITS+FRAC_W-1:FRAC_W];
      qb[0]  <= prod[FRAC_W-1:0];
      dv[0]  <= in_div;
      ctl[0] <= in_ctrl;
    end
  end

  for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
    logic [TIME_BITS:0] r2;
    logic [TIME_BITS:0] diff;
    logic               ge;

    if (k < FRAC_W) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end

    assign r2   = {rem[k-1], qb[k-1][FRAC_W-1]};
    assign diff = r2 - {1'b0, dv[k-1]};
    assign ge   = r2 >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k] <= ge ? diff[TIME_BITS-1:0] : r2[TIME_BITS-1:0];
        qb[k]  <= {qb[k-1][FRAC_W-2:0], ge};
        dv[k]  <= dv[k-1];
        ctl[k] <= ctl[k-1];
      end
    end
  end

  assign out_valid = vld[FRAC_W];
  assign out_quot  = qb[FRAC_W];
  assign out_ctrl  = ctl[FRAC_W];

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    vld[FRAC_W] |-> rem[FRAC_W] < dv[FRAC_W])
    else $error("final remainder not below divisor");

endmodule

// ----- design/adsr_envelope_level.sv -----
`timescale 1ns / 1ps
// Top level of the linear ADSR envelope level block.
// Pipeline: 4 classify, 1 multiply, 15 divide stages and 1 output register.
// Throughput: one beat per cycle unless m_tready stalls, set by the pipelined divider.
// Reset clears all valid bits and loads the default envelope registers.
module adsr_envelope_level #(
  parameter int TIME_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // elapsed_time
  input  logic [((TIME_BITS+7)/8)*8-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // envelope_level
  output logic [adsr_pkg::LEVEL_W-1:0]          m_tdata,
  // stage_code
  output logic [adsr_pkg::STAGE_W-1:0]          m_tuser,
  input  logic                                  cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [TIME_BITS-1:0]                  cfg_wdata
);
  import adsr_pkg::*;

  logic [TIME_BITS-1:0] attack_eff;
  logic [TIME_BITS-1:0] decay_eff;
  logic [TIME_BITS-1:0] hold_eff;
  logic [TIME_BITS-1:0] release_eff;
  logic [LEVEL_W-1:0]   sustain_eff;

  logic                 sel_valid;
  logic                 sel_ready;
  logic [TIME_BITS-1:0] sel_x;
  logic [TIME_BITS-1:0] sel_div;
  logic [LEVEL_W-1:0]   sel_mult;
  ctrl_t                sel_ctrl;

  logic                 div_valid;
  logic                 div_ready;
  logic [FRAC_W-1:0]    div_quot;
  ctrl_t                div_ctrl;

  logic                 out_valid;
  logic [LEVEL_W-1:0]   level;
  stage_t               stage;
  logic [LEVEL_W-1:0]   level_next;

  adsr_cfg #(.TIME_BITS(TIME_BITS)) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .attack_eff  (attack_eff),
    .decay_eff   (decay_eff),
    .hold_eff    (hold_eff),
    .release_eff (release_eff),
    .sustain_eff (sustain_eff)
  );

  adsr_sel #(.TIME_BITS(TIME_BITS)) u_sel (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_time     (s_tdata[TIME_BITS-1:0]),
    .attack_eff  (attack_eff),
    .decay_eff   (decay_eff),
    .hold_eff    (hold_eff),
    .release_eff (release_eff),
    .sustain_eff (sustain_eff),
    .out_valid   (sel_valid),
    .out_ready   (sel_ready),
    .out_x       (sel_x),
    .out_div     (sel_div),
    .out_mult    (sel_mult),
    .out_ctrl    (sel_ctrl)
  );

  adsr_div #(.TIME_BITS(TIME_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_x      (sel_x),
    .in_div    (sel_div),
    .in_mult   (sel_mult),
    .in_ctrl   (sel_ctrl),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (div_quot),
    .out_ctrl  (div_ctrl)
  );

  assign div_ready  = !out_valid || m_tready;
  assign level_next = (div_ctrl.stage == ST_ATTACK) ? {1'b0, div_quot}
                                                    : div_ctrl.base - {1'b0, div_quot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_ready) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      level <= level_next;
      stage <= div_ctrl.stage;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = level;
  assign m_tuser  = stage;

  a_done_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_DONE) |-> m_tdata == '0)
    else $error("finished stage with nonzero level");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= FULL_SCALE)
    else $error("level above full scale");

  a_attack_below_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ATTACK) |-> m_tdata < FULL_SCALE)
    else $error("attack level reached full scale");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the ADSR envelope level block: directed table, then random register phases.
module testbench;
  import adsr_pkg::*;

  localparam int TIME_BITS = 24;
  localparam int DATA_W = ((TIME_BITS + 7) / 8) * 8;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int PIPE_DEPTH = 21;
  localparam int LONG_HOLD = 150;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS = 73;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    stage_t             stage;
  } envelope_t;

  typedef enum bit {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [TIME_BITS-1:0]   value;
    bit                     typed;
    envelope_t              result;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // elapsed_time
  logic [DATA_W-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // envelope_level
  logic [LEVEL_W-1:0]   m_tdata;
  // stage_code
  logic [STAGE_W-1:0]   m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_BITS-1:0] cfg_wdata = '0;

  logic [TIME_BITS-1:0] attack_reg = TIME_BITS'(RST_ATTACK);
  logic [TIME_BITS-1:0] decay_reg = TIME_BITS'(RST_DECAY);
  logic [LEVEL_W-1:0]   sustain_reg = LEVEL_W'(RST_SUSTAIN);
  logic [TIME_BITS-1:0] hold_reg = TIME_BITS'(RST_HOLD);
  logic [TIME_BITS-1:0] release_reg = TIME_BITS'(RST_RELEASE);

  envelope_t levels_due[$];
  stim_row_t stim_rows[$];
  int        mismatches = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;
  bit        quiet = 1'b0;

  adsr_envelope_level #(
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned raised(input logic [TIME_BITS-1:0] x);
    longint unsigned v;
    v = x;
    if (v < MIN_STAGE) v = MIN_STAGE;
    return v;
  endfunction

  function automatic envelope_t envelope_at(input logic [TIME_BITS-1:0] t);
    longint unsigned a, d, r, h, s, x, fs, lvl;
    envelope_t e;
    a = raised(attack_reg);
    d = raised(decay_reg);
    r = raised(release_reg);
    h = hold_reg;
    fs = FULL_SCALE;
    s = sustain_reg;
    if (s > fs) s = fs;
    x = t;
    if (x < a) begin
      lvl = (x * fs) / a;
      e.stage = ST_ATTACK;
    end else if (x - a < d) begin
      lvl = fs - ((fs - s) * (x - a)) / d;
      e.stage = ST_DECAY;
    end else if (x - a - d < h) begin
      lvl = s;
      e.stage = ST_HOLD;
    end else if (x - a - d - h < r) begin
      lvl = s - (s * (x - a - d - h)) / r;
      e.stage = ST_RELEASE;
    end else begin
      lvl = 0;
      e.stage = ST_DONE;
    end
    e.level = lvl[LEVEL_W-1:0];
    return e;
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_time();
    longint unsigned a, d, h, r, mark, pick;
    a = raised(attack_reg);
    d = raised(decay_reg);
    h = hold_reg;
    r = raised(release_reg);
    case ($urandom_range(0, 3))
      0: pick = $urandom_range(0, TIME_MAX);
      1, 2: begin
        case ($urandom_range(0, 3))
          0: mark = a;
          1: mark = a + d;
          2: mark = a + d + h;
          default: mark = a + d + h + r;
        endcase
        pick = mark + $urandom_range(0, 8);
        pick = (pick < 4) ? 0 : pick - 4;
      end
      default: pick = longint'($urandom) % (a + d + h + r + (a + d + h + r) / 4 + 1);
    endcase
    if (pick > TIME_MAX) pick = TIME_MAX;
    return pick[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_duration();
    case ($urandom_range(0, 6))
      0, 1: return TIME_BITS'($urandom_range(0, 2 * MIN_STAGE));
      2, 3: return TIME_BITS'($urandom_range(15, 2000));
      4: return TIME_BITS'($urandom_range(0, 262143));
      5: return TIME_BITS'($urandom_range(0, TIME_MAX));
      default: return TIME_MAX;
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_sustain();
    logic [LEVEL_W-1:0] lvl;
    case ($urandom_range(0, 3))
      0: lvl = '0;
      1: lvl = FULL_SCALE;
      2: lvl = LEVEL_W'($urandom_range(0, FULL_SCALE));
      default: lvl = LEVEL_W'($urandom_range(0, 65535));
    endcase
    return {8'($urandom_range(0, 255)), lvl};
  endfunction

  function automatic void put_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [TIME_BITS-1:0] value);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.index = idx;
    row.value = value;
    row.typed = 1'b0;
    row.result = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void put_beat(input logic [TIME_BITS-1:0] t, input bit typed,
                                   input logic [LEVEL_W-1:0] lvl, input stage_t st);
    stim_row_t row;
    row.kind = ROW_BEAT;
    row.index = '0;
    row.value = t;
    row.typed = typed;
    row.result.level = lvl;
    row.result.stage = st;
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_ATTACK: attack_reg = value;
      REG_DECAY: decay_reg = value;
      REG_SUSTAIN: sustain_reg = value[LEVEL_W-1:0];
      REG_HOLD: hold_reg = value;
      REG_RELEASE: release_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (levels_due.size() != 0) @(negedge clk);
  endtask

  task automatic offer_time(input logic [TIME_BITS-1:0] t, input bit typed,
                            input envelope_t given);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_W'(t);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    levels_due.push_back(typed ? given : envelope_at(t));
    beats_in++;
    @(negedge clk);
  endtask

  task automatic run_phase(input int beats);
    int pause_at;
    drain();
    write_reg(REG_ATTACK, rand_duration());
    write_reg(REG_DECAY, rand_duration());
    write_reg(REG_SUSTAIN, rand_sustain());
    write_reg(REG_HOLD, rand_duration());
    write_reg(REG_RELEASE, rand_duration());
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                TIME_BITS'($urandom_range(0, TIME_MAX)));
    pause_at = $urandom_range(1, beats - 1);
    for (int i = 0; i < beats; i++) begin
      if (i == pause_at) drain();
      offer_time(pick_time(), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && beats_out >= 100 && levels_due.size() >= 8) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    envelope_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (levels_due.size() == 0) begin
        report_mismatch($sformatf("output beat %0d with nothing expected", beats_out));
      end else begin
        want = levels_due.pop_front();
        if (m_tdata !== want.level)
          report_mismatch($sformatf("beat %0d level %0d, want %0d",
                                    beats_out, m_tdata, want.level));
        if (m_tuser !== want.stage)
          report_mismatch($sformatf("beat %0d stage %0d, want %0d",
                                    beats_out, m_tuser, want.stage));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    put_beat(24'd0, 1'b1, 16'd0, ST_ATTACK);
    put_beat(24'd654, 1'b0, '0, ST_ATTACK);
    put_beat(24'd655, 1'b1, FULL_SCALE, ST_DECAY);
    put_beat(24'd7209, 1'b1, 16'd22938, ST_HOLD);
    put_beat(24'd39977, 1'b1, 16'd22938, ST_RELEASE);
    put_beat(24'd53083, 1'b0, '0, ST_RELEASE);
    put_beat(24'd53084, 1'b1, 16'd0, ST_DONE);
    put_beat(TIME_MAX, 1'b1, 16'd0, ST_DONE);
    put_write(REG_ATTACK, 24'd0);
    put_write(REG_DECAY, 24'd0);
    put_write(REG_RELEASE, 24'd0);
    put_write(REG_HOLD, 24'd0);
    put_write(REG_SUSTAIN, TIME_MAX);
    put_beat(24'd3, 1'b0, '0, ST_ATTACK);
    put_beat(24'd7, 1'b1, FULL_SCALE, ST_DECAY);
    put_beat(24'd14, 1'b1, FULL_SCALE, ST_RELEASE);
    put_beat(24'd20, 1'b0, '0, ST_RELEASE);
    put_beat(24'd21, 1'b1, 16'd0, ST_DONE);
    put_write(REG_SPARE_LO, 24'h123456);
    put_write(REG_SPARE_HI, TIME_MAX);
    put_write(REG_SUSTAIN, 24'd0);
    put_beat(24'd7, 1'b1, FULL_SCALE, ST_DECAY);
    put_beat(24'd10, 1'b0, '0, ST_DECAY);
    put_beat(24'd14, 1'b1, 16'd0, ST_RELEASE);
    put_write(REG_ATTACK, TIME_MAX);
    put_write(REG_DECAY, TIME_MAX);
    put_write(REG_HOLD, TIME_MAX);
    put_write(REG_RELEASE, TIME_MAX);
    put_write(REG_SUSTAIN, 24'(FULL_SCALE));
    put_beat(24'd0, 1'b1, 16'd0, ST_ATTACK);
    put_beat(TIME_MAX, 1'b1, FULL_SCALE, ST_DECAY);
    put_beat(TIME_MAX - 24'd1, 1'b0, '0, ST_ATTACK);
    put_beat(24'h800000, 1'b0, '0, ST_ATTACK);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(stim_rows[i].index, stim_rows[i].value);
      end else begin
        offer_time(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].result);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) quiet = 1'b1;
      run_phase(PHASE_BEATS);
    end

    s_tvalid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
